// File: sv/fixed_point_alu_macros.svh
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Concurrent checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

`ifndef SYNTHESIS
// Check that holds at every clock edge outside reset
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that the antecedent implies the consequent in the next cycle
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPA_ASSERT(lbl, prop, msg)
`define FPA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Widths, operation codes and the item tag shared by the pipeline stages.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int DataW        = 32;
  localparam int OpW          = 4;
  localparam int FracBitsDef  = 8;
  // divider: 64 quotient bits, four per stage
  localparam int DivW         = 2 * DataW;
  localparam int DivBitsPerSt = 4;
  localparam int DivStages    = DivW / DivBitsPerSt;

  typedef enum logic [OpW-1:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_INC      = 4'd4,
    OP_DEC      = 4'd5,
    OP_MIN      = 4'd6,
    OP_MAX      = 4'd7,
    OP_FROM_INT = 4'd8,
    OP_TO_INT   = 4'd9
  } op_e;

  // side data that travels next to the divider
  typedef struct packed {
    logic [DataW-1:0] res;
    logic             ovf;
    logic             dbz;
    logic             less;
    logic             equal;
    logic             greater;
    logic             is_div;
  } tag_t;

endpackage

// File: sv/fpa_if.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU channels
// Request and response handshake interfaces with valid, ready and payload.
// ----------------------------------------------------------------------------
interface fpa_req_if;
  logic                             valid;
  logic                             ready;
  logic [fpa_pkg::OpW-1:0]          req_type;
  logic signed [fpa_pkg::DataW-1:0] operand_a;
  logic signed [fpa_pkg::DataW-1:0] operand_b;

  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [fpa_pkg::DataW-1:0] result;
  logic                             less;
  logic                             equal;
  logic                             greater;
  logic                             overflow;
  logic                             div_by_zero;

  modport source (output valid, result, less, equal, greater, overflow, div_by_zero,
                  input ready);
  modport sink   (input valid, result, less, equal, greater, overflow, div_by_zero,
                  output ready);
endinterface

// File: sv/fpa_mul.sv
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// Registered 32x32 product, then scaling toward zero and overflow detect.
// ----------------------------------------------------------------------------
module fpa_mul #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [fpa_pkg::DataW-1:0] a_i,
  input  logic signed [fpa_pkg::DataW-1:0] b_i,
  output logic        [fpa_pkg::DataW-1:0] res_o,
  output logic                             ovf_o
);
  import fpa_pkg::*;

  localparam logic signed [DivW-1:0] Bias = (DivW'(1) <<< FRAC_BITS) - DivW'(1);

  logic signed [DivW-1:0] prod_q;
  logic signed [DivW-1:0] adj;
  logic signed [DivW-1:0] quo;

  // product register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  // divide by 2^FRAC_BITS, rounding toward zero
  always_comb begin
    adj   = prod_q + (prod_q[DivW-1] ? Bias : '0);
    quo   = adj >>> FRAC_BITS;
    res_o = quo[DataW-1:0];
    ovf_o = ~((&quo[DivW-1:DataW-1]) | ~(|quo[DivW-1:DataW-1]));
  end

endmodule

// File: sv/fpa_div.sv
// ----------------------------------------------------------------------------
// Fixed-point divider
// Unsigned restoring divider, four quotient bits per register stage.
// ----------------------------------------------------------------------------
module fpa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [fpa_pkg::DivW-1:0]  num_i,
  input  logic [fpa_pkg::DataW-1:0] den_i,
  input  logic                      neg_i,
  input  fpa_pkg::tag_t             tag_i,
  output logic                      valid_o,
  output logic [fpa_pkg::DivW-1:0]  quo_o,
  output logic                      neg_o,
  output fpa_pkg::tag_t             tag_o
);
  import fpa_pkg::*;

  // index 0 is the module input, index s+1 the output of stage s
  logic             vld_w [DivStages+1];
  logic [DataW-1:0] rem_w [DivStages+1];
  logic [DivW-1:0]  nq_w  [DivStages+1];
  logic [DataW-1:0] den_w [DivStages+1];
  logic             neg_w [DivStages+1];
  tag_t             tag_w [DivStages+1];

  assign vld_w[0] = valid_i;
  assign rem_w[0] = '0;
  assign nq_w[0]  = num_i;
  assign den_w[0] = den_i;
  assign neg_w[0] = neg_i;
  assign tag_w[0] = tag_i;

  for (genvar s = 0; s < DivStages; s++) begin : g_stg
    logic             vld_q;
    logic [DataW-1:0] rem_q;
    logic [DivW-1:0]  nq_q;
    logic [DataW-1:0] den_q;
    logic             neg_q;
    tag_t             tag_q;
    logic [DataW-1:0] rem_d;
    logic [DivW-1:0]  nq_d;

    // shift-subtract steps for this stage's quotient bits
    always_comb begin
      logic [DataW:0] part;
      logic           ge;
      rem_d = rem_w[s];
      nq_d  = nq_w[s];
      for (int k = 0; k < DivBitsPerSt; k++) begin
        part  = {rem_d, nq_d[DivW-1]};
        ge    = (part >= {1'b0, den_w[s]});
        part  = ge ? (part - {1'b0, den_w[s]}) : part;
        rem_d = part[DataW-1:0];
        nq_d  = {nq_d[DivW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= rem_d;
        nq_q  <= nq_d;
        den_q <= den_w[s];
        neg_q <= neg_w[s];
        tag_q <= tag_w[s];
      end
    end

    assign vld_w[s+1] = vld_q;
    assign rem_w[s+1] = rem_q;
    assign nq_w[s+1]  = nq_q;
    assign den_w[s+1] = den_q;
    assign neg_w[s+1] = neg_q;
    assign tag_w[s+1] = tag_q;
  end

  assign valid_o = vld_w[DivStages];
  assign quo_o   = nq_w[DivStages];
  assign neg_o   = neg_w[DivStages];
  assign tag_o   = tag_w[DivStages];

endmodule

// File: sv/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed 32-bit fixed-point ALU with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request item: req_type, operand_a, operand_b.
//   rsp_o returns one response item per request, in request order:
//   result, less, equal, greater, overflow, div_by_zero.
//   Every operation takes the same path: input register, operand
//   decode and multiply register, then DivStages divider stages (four
//   quotient bits each, 16 stages) and the output register. Throughput
//   is one item per cycle while the pipeline is not frozen;
//   req_i.ready is high whenever the output register is empty or is
//   being taken.
//   Reset clears all valid bits; the pipeline comes up empty.
//   When the receiver holds rsp_o.ready low with a result waiting, the
//   whole pipeline freezes in place and req_i.ready drops; nothing is
//   dropped or repeated.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_macros.svh"

module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  fpa_req_if.sink   req_i,
  fpa_rsp_if.source rsp_o
);
  import fpa_pkg::*;

  logic pipe_en;

  // input register
  logic                    a_valid_q;
  op_e                     a_op_q;
  logic signed [DataW-1:0] a_opa_q;
  logic signed [DataW-1:0] a_opb_q;

  // operand stage outputs
  tag_t             a_tag;
  logic [DataW-1:0] a_abs_a;
  logic [DataW-1:0] a_abs_b;
  logic [DivW-1:0]  a_num;

  // decode stage registers
  logic             b_valid_q;
  op_e              b_op_q;
  tag_t             b_tag_q;
  logic [DivW-1:0]  b_num_q;
  logic [DataW-1:0] b_den_q;
  logic             b_neg_q;
  tag_t             b_tag;

  logic [DataW-1:0] mul_res;
  logic             mul_ovf;

  logic             d_valid;
  logic [DivW-1:0]  d_quo;
  logic             d_neg;
  tag_t             d_tag;

  logic [DataW-1:0] o_res;
  logic             o_ovf;

  logic             out_valid_q;
  logic [DataW-1:0] out_res_q;
  logic             out_less_q;
  logic             out_equal_q;
  logic             out_greater_q;
  logic             out_ovf_q;
  logic             out_dbz_q;

  // global advance: move whenever the output slot is free or taken
  assign pipe_en     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = pipe_en;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (pipe_en) begin
      a_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_op_q  <= op_e'(req_i.req_type);
      a_opa_q <= req_i.operand_a;
      a_opb_q <= req_i.operand_b;
    end
  end

  // simple operations, compare flags and divider operands
  always_comb begin
    logic signed [DataW:0]   wide;
    logic signed [DivW-1:0]  fi;
    a_tag         = '0;
    a_tag.less    = (a_opa_q < a_opb_q);
    a_tag.equal   = (a_opa_q == a_opb_q);
    a_tag.greater = (a_opa_q > a_opb_q);
    wide          = '0;
    fi            = DivW'(a_opa_q) <<< FRAC_BITS;
    case (a_op_q)
      OP_ADD: begin
        wide      = {a_opa_q[DataW-1], a_opa_q} + {a_opb_q[DataW-1], a_opb_q};
        a_tag.res = wide[DataW-1:0];
        a_tag.ovf = wide[DataW] ^ wide[DataW-1];
      end
      OP_SUB: begin
        wide      = {a_opa_q[DataW-1], a_opa_q} - {a_opb_q[DataW-1], a_opb_q};
        a_tag.res = wide[DataW-1:0];
        a_tag.ovf = wide[DataW] ^ wide[DataW-1];
      end
      OP_INC: begin
        wide      = {a_opa_q[DataW-1], a_opa_q} + (DataW+1)'(1);
        a_tag.res = wide[DataW-1:0];
        a_tag.ovf = wide[DataW] ^ wide[DataW-1];
      end
      OP_DEC: begin
        wide      = {a_opa_q[DataW-1], a_opa_q} - (DataW+1)'(1);
        a_tag.res = wide[DataW-1:0];
        a_tag.ovf = wide[DataW] ^ wide[DataW-1];
      end
      OP_MIN: begin
        a_tag.res = (a_opa_q <= a_opb_q) ? a_opa_q : a_opb_q;
      end
      OP_MAX: begin
        a_tag.res = (a_opa_q >= a_opb_q) ? a_opa_q : a_opb_q;
      end
      OP_FROM_INT: begin
        a_tag.res = fi[DataW-1:0];
        a_tag.ovf = ~((&fi[DivW-1:DataW-1]) | ~(|fi[DivW-1:DataW-1]));
      end
      OP_TO_INT: begin
        a_tag.res = a_opa_q >>> FRAC_BITS;
      end
      OP_DIV: begin
        a_tag.dbz    = (a_opb_q == '0);
        a_tag.is_div = (a_opb_q != '0);
      end
      default: begin
        a_tag.res = '0;
      end
    endcase
  end

  assign a_abs_a = a_opa_q[DataW-1] ? DataW'(-a_opa_q) : DataW'(a_opa_q);
  assign a_abs_b = a_opb_q[DataW-1] ? DataW'(-a_opb_q) : DataW'(a_opb_q);
  assign a_num   = DivW'(a_abs_a) << FRAC_BITS;

  fpa_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .a_i   (a_opa_q),
    .b_i   (a_opb_q),
    .res_o (mul_res),
    .ovf_o (mul_ovf)
  );

  // decode stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (pipe_en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      b_op_q  <= a_op_q;
      b_tag_q <= a_tag;
      b_num_q <= a_num;
      b_den_q <= a_abs_b;
      b_neg_q <= a_opa_q[DataW-1] ^ a_opb_q[DataW-1];
    end
  end

  // merge the scaled product into the tag
  always_comb begin
    b_tag = b_tag_q;
    if (b_op_q == OP_MUL) begin
      b_tag.res = mul_res;
      b_tag.ovf = mul_ovf;
    end
  end

  fpa_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (b_valid_q),
    .num_i   (b_num_q),
    .den_i   (b_den_q),
    .neg_i   (b_neg_q),
    .tag_i   (b_tag),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .neg_o   (d_neg),
    .tag_o   (d_tag)
  );

  // signed quotient and its range check, or the side result
  always_comb begin
    o_res = d_tag.res;
    o_ovf = d_tag.ovf;
    if (d_tag.is_div) begin
      o_res = d_neg ? DataW'(-d_quo[DataW-1:0]) : d_quo[DataW-1:0];
      if (d_neg) begin
        o_ovf = (|d_quo[DivW-1:DataW]) || (d_quo[DataW-1] && (|d_quo[DataW-2:0]));
      end else begin
        o_ovf = |d_quo[DivW-1:DataW-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_res_q     <= o_res;
      out_less_q    <= d_tag.less;
      out_equal_q   <= d_tag.equal;
      out_greater_q <= d_tag.greater;
      out_ovf_q     <= o_ovf;
      out_dbz_q     <= d_tag.dbz;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.result      = out_res_q;
  assign rsp_o.less        = out_less_q;
  assign rsp_o.equal       = out_equal_q;
  assign rsp_o.greater     = out_greater_q;
  assign rsp_o.overflow    = out_ovf_q;
  assign rsp_o.div_by_zero = out_dbz_q;

  // checks
  `FPA_ASSERT(a_dbz_zero, rsp_o.valid && rsp_o.div_by_zero |-> rsp_o.result == '0 && !rsp_o.overflow, "divide by zero gave a nonzero result or overflow")
  `FPA_ASSERT(a_cmp_onehot, rsp_o.valid |-> $onehot({rsp_o.less, rsp_o.equal, rsp_o.greater}), "compare flags not one-hot")
  `FPA_ASSERT(a_empty_ready, !rsp_o.valid |-> req_i.ready, "empty output slot but input not ready")
  `FPA_ASSERT_NEXT(a_stall_freeze, !pipe_en, $stable(b_valid_q) && $stable(d_valid), "pipeline moved while stalled")

endmodule
